>>> hdl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Shared constants and types of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CHAR    = 3'd1;
	localparam logic [2:0] ST_DIV0    = 3'd2;
	localparam logic [2:0] ST_OVF     = 3'd3;
	localparam logic [2:0] ST_MISSING = 3'd4;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item
		logic digit;     // fold digit into accumulator
		logic flush;     // push accumulator if a number is open
		logic rd_top;    // read top two values and top operator
		logic red_go;    // start reduction on read operands
		logic red_done;  // write back reduction result
		logic push_op;   // push captured operator
		logic clear;     // clear counts, flags, error and accumulator
		logic rd_bottom; // read value at stack bottom
		logic out_load;  // load output register
		logic [2:0] set_err;
		logic set_err_en;
	} iee_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic is_end;
		logic err;
		logic ops_empty;
		logic ops_full;
		logic vals_lt2;
		logic vals_full;
		logic vals_one;
		logic in_number;
		logic top_ge;     // top operator precedence >= incoming, or end item
		logic div_zero;   // read divisor is zero and op is divide
		logic red_busy;
		logic red_ready;
	} iee_sts_t;

endpackage

>>> hdl/iee_divider.sv
// ----------------------------------------------------------------------------
// iee_divider
// Restoring signed divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module iee_divider #(
	parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   busy,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quotient
);
	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q, busy_q, done_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH-1:0] ma, mb;

	assign ma    = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
	assign mb    = divisor[VALUE_WIDTH-1] ? (~divisor + 1'b1) : divisor;
	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= ma;
			den_q <= mb;
			neg_q <= dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
		end else if (busy_q) begin
			if (!trial[VALUE_WIDTH]) begin
				rem_q <= trial[VALUE_WIDTH-1:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[VALUE_WIDTH-2:0], quo_q[VALUE_WIDTH-1]};
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

>>> hdl/iee_datapath.sv
// ----------------------------------------------------------------------------
// iee_datapath
// Stacks, digit accumulator, arithmetic unit and output register.
// ----------------------------------------------------------------------------
module iee_datapath #(
	parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  iee_pkg::iee_cmd_t cmd,
	output iee_pkg::iee_sts_t sts,
	input  logic [7:0]        char_code,
	input  logic              end_of_expression,
	output logic [31:0]       value,
	output logic [2:0]        status
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [VALUE_WIDTH-1:0] vmem [STACK_DEPTH];
	logic [1:0]             omem [STACK_DEPTH];
	logic [CW-1:0]          vcnt_q, ocnt_q;
	logic [VALUE_WIDTH-1:0] acc_q, a_q, b_q, res_q, mul_q;
	logic [1:0]             op_q, top_q;
	logic                   innum_q, end_q;
	logic [2:0]             err_q;
	logic [7:0]             ch_q;
	logic [1:0]             new_op;
	logic                   div_busy, div_done;
	logic [VALUE_WIDTH-1:0] quot;
	logic                   div_start, vpush;
	logic [VALUE_WIDTH-1:0] vpush_d;
	logic [31:0]            val_q;
	logic [2:0]             stat_q;

	always_comb begin
		case (ch_q)
			iee_pkg::CH_PLUS:  new_op = iee_pkg::OP_ADD;
			iee_pkg::CH_MINUS: new_op = iee_pkg::OP_SUB;
			iee_pkg::CH_STAR:  new_op = iee_pkg::OP_MUL;
			default:           new_op = iee_pkg::OP_DIV;
		endcase
	end

	assign div_start = cmd.red_go && (top_q == iee_pkg::OP_DIV);

	iee_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(a_q),
		.divisor(b_q), .busy(div_busy), .done(div_done), .quotient(quot)
	);

	// result of reduction
	always_comb begin
		case (top_q)
			iee_pkg::OP_ADD: res_q = a_q + b_q;
			iee_pkg::OP_SUB: res_q = a_q - b_q;
			iee_pkg::OP_MUL: res_q = mul_q;
			default:         res_q = quot;
		endcase
	end

	assign vpush   = cmd.flush && innum_q && (vcnt_q != CW'(STACK_DEPTH));
	assign vpush_d = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q  <= '0;
			ocnt_q  <= '0;
			innum_q <= 1'b0;
			err_q   <= iee_pkg::ST_OK;
			acc_q   <= '0;
		end else begin
			if (cmd.clear) begin
				vcnt_q  <= '0;
				ocnt_q  <= '0;
				innum_q <= 1'b0;
				err_q   <= iee_pkg::ST_OK;
				acc_q   <= '0;
			end else begin
				if (cmd.set_err_en && err_q == iee_pkg::ST_OK)
					err_q <= cmd.set_err;
				if (cmd.digit) begin
					acc_q   <= (innum_q ? acc_q * VALUE_WIDTH'(10) : '0)
						+ VALUE_WIDTH'(ch_q - iee_pkg::CH_ZERO);
					innum_q <= 1'b1;
				end
				if (cmd.flush) begin
					innum_q <= 1'b0;
					acc_q   <= '0;
					if (vpush)
						vcnt_q <= vcnt_q + 1'b1;
				end
				if (cmd.red_done) begin
					vcnt_q <= vcnt_q - 1'b1;
					ocnt_q <= ocnt_q - 1'b1;
				end
				if (cmd.push_op)
					ocnt_q <= ocnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= char_code;
			end_q <= end_of_expression;
		end
		if (vpush)
			vmem[vcnt_q[AW-1:0]] <= vpush_d;
		if (cmd.red_done)
			vmem[AW'(vcnt_q - CW'(2))] <= res_q;
		if (cmd.push_op)
			omem[ocnt_q[AW-1:0]] <= new_op;
		if (cmd.rd_top) begin
			b_q   <= vmem[AW'(vcnt_q - CW'(1))];
			a_q   <= vmem[AW'(vcnt_q - CW'(2))];
			top_q <= omem[AW'(ocnt_q - CW'(1))];
		end
		if (cmd.rd_bottom)
			a_q <= vmem[0];
		if (cmd.red_go)
			mul_q <= a_q * b_q;
		if (cmd.out_load) begin
			val_q  <= (err_q == iee_pkg::ST_OK)
				? 32'(signed'(a_q)) : 32'd0;
			stat_q <= err_q;
		end
	end

	// top_ge uses the top operator read in the previous cycle
	always_comb begin
		sts.is_digit  = (ch_q >= iee_pkg::CH_ZERO) && (ch_q <= iee_pkg::CH_NINE);
		sts.is_op     = (ch_q == iee_pkg::CH_PLUS) || (ch_q == iee_pkg::CH_MINUS) ||
			(ch_q == iee_pkg::CH_STAR) || (ch_q == iee_pkg::CH_SLASH);
		sts.is_end    = end_q;
		sts.err       = (err_q != iee_pkg::ST_OK);
		sts.ops_empty = (ocnt_q == '0);
		sts.ops_full  = (ocnt_q == CW'(STACK_DEPTH));
		sts.vals_lt2  = (vcnt_q < CW'(2));
		sts.vals_full = (vcnt_q == CW'(STACK_DEPTH));
		sts.vals_one  = (vcnt_q == CW'(1));
		sts.in_number = innum_q;
		sts.top_ge    = (top_q[1] >= new_op[1]) || end_q;
		sts.div_zero  = (top_q == iee_pkg::OP_DIV) && (b_q == '0);
		sts.red_busy  = div_busy || div_start || (cmd.red_go && top_q == iee_pkg::OP_MUL);
		// product is registered on red_go, before the write-back state
		sts.red_ready = (top_q == iee_pkg::OP_DIV) ? div_done : 1'b1;
	end

	assign value  = val_q;
	assign status = stat_q;
endmodule

>>> hdl/iee_control.sv
// ----------------------------------------------------------------------------
// iee_control
// Sequencer: digit folding, reduction loop, operator push, end of item.
// ----------------------------------------------------------------------------
module iee_control (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output iee_pkg::iee_cmd_t cmd,
	input  iee_pkg::iee_sts_t sts
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DEC   = 9'b000000010,
		S_CHECK = 9'b000000100,
		S_READ  = 9'b000001000,
		S_TEST  = 9'b000010000,
		S_WAIT  = 9'b000100000,
		S_PUSH  = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t st_q, st_d;
	logic   ov_q, ov_d;

	always_comb begin
		st_d = st_q;
		ov_d = ov_q;
		cmd  = '0;
		if (out_valid && out_ready)
			ov_d = 1'b0;
		in_ready = (st_q == S_IDLE);
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_end) begin
					if (sts.err) begin
						st_d = S_FIN;
					end else begin
						cmd.flush = 1'b1;
						if (sts.in_number && sts.vals_full) begin
							cmd.set_err_en = 1'b1;
							cmd.set_err = iee_pkg::ST_OVF;
						end
						st_d = S_CHECK;
					end
				end else if (sts.err) begin
					st_d = S_IDLE;
				end else if (sts.is_digit) begin
					cmd.digit = 1'b1;
					st_d = S_IDLE;
				end else if (sts.is_op) begin
					cmd.flush = 1'b1;
					if (sts.in_number && sts.vals_full) begin
						cmd.set_err_en = 1'b1;
						cmd.set_err = iee_pkg::ST_OVF;
					end
					st_d = S_CHECK;
				end else begin
					cmd.set_err_en = 1'b1;
					cmd.set_err = iee_pkg::ST_CHAR;
					st_d = S_IDLE;
				end
			end
			S_CHECK: begin
				if (sts.err)
					st_d = sts.is_end ? S_FIN : S_IDLE;
				else if (sts.ops_empty)
					st_d = sts.is_end ? S_FIN : S_PUSH;
				else begin
					cmd.rd_top = 1'b1;
					st_d = S_READ;
				end
			end
			S_READ: begin
				if (!sts.top_ge)
					st_d = S_PUSH;
				else if (sts.vals_lt2) begin
					cmd.set_err_en = 1'b1;
					cmd.set_err = iee_pkg::ST_MISSING;
					st_d = sts.is_end ? S_FIN : S_IDLE;
				end else if (sts.div_zero) begin
					cmd.set_err_en = 1'b1;
					cmd.set_err = iee_pkg::ST_DIV0;
					st_d = sts.is_end ? S_FIN : S_IDLE;
				end else begin
					cmd.red_go = 1'b1;
					st_d = S_TEST;
				end
			end
			S_TEST: st_d = S_WAIT;
			S_WAIT: begin
				if (sts.red_ready) begin
					cmd.red_done = 1'b1;
					st_d = S_CHECK;
				end
			end
			S_PUSH: begin
				if (sts.ops_full) begin
					cmd.set_err_en = 1'b1;
					cmd.set_err = iee_pkg::ST_OVF;
				end else
					cmd.push_op = 1'b1;
				st_d = S_IDLE;
			end
			S_FIN: begin
				if (!sts.err && !sts.vals_one) begin
					cmd.set_err_en = 1'b1;
					cmd.set_err = iee_pkg::ST_MISSING;
				end
				cmd.rd_bottom = 1'b1;
				st_d = S_OUT;
			end
			S_OUT: begin
				if (!ov_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.clear = 1'b1;
					ov_d = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;
endmodule

>>> hdl/infix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Two-stack infix evaluator taking one character item at a time.
// ----------------------------------------------------------------------------
// A digit or error item returns straight to idle. An operator reduces while
// the top operator ranks no lower, a / waiting on the divider, then is pushed.
// End item: reductions, then the result is loaded once the last one is taken.
// Asynchronous active-low reset clears counts, flags and control; stacks
// are left undefined and entries above their counts are never used.
module infix_expression_evaluator_unit #(
	parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_expression,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic [2:0]  status
);
	iee_pkg::iee_cmd_t cmd;
	iee_pkg::iee_sts_t sts;

	iee_control u_ctl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	iee_datapath #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.char_code(char_code), .end_of_expression(end_of_expression),
		.value(value), .status(status)
	);
endmodule

>>> hdl/iee_checker.sv
// ----------------------------------------------------------------------------
// iee_checker
// Port-level checks of the evaluator.
// ----------------------------------------------------------------------------
module iee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic [2:0]  status
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
		else $error("result dropped while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'd4)
		else $error("status out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'd0 |-> value == 32'd0)
		else $error("nonzero value with error");

	a_no_take_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted on consecutive cycles");
endmodule

bind infix_expression_evaluator_unit iee_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .value(value), .status(status)
);
